/* design/fdt_pkg.sv */
// Shared constants and types for the fixed-point to decimal text converter.
package fdt_pkg;

  localparam int FdtIntBits        = 32;
  localparam int FdtFracBits       = 16;
  localparam int FdtFractionDigits = 3;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2d;
  localparam logic [7:0] AsciiPoint = 8'h2e;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } fdt_cell_ctrl_t;

endpackage

/* design/fdt_bcd_cell.sv */
// One decimal digit cell of the binary to BCD chain, with shift-add-3 and digit move.
module fdt_bcd_cell (
  input  logic                   clk_i,
  input  fdt_pkg::fdt_cell_ctrl_t ctrl_i,
  input  logic                   bit_i,
  input  logic [3:0]             digit_i,
  output logic                   bit_o,
  output logic [3:0]             digit_o
);
  import fdt_pkg::*;

  logic [3:0] digit_q;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      digit_q <= 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_q <= {adj[2:0], bit_i};
    end else if (ctrl_i.move) begin
      digit_q <= digit_i;
    end
  end

endmodule

/* design/fixed_to_decimal_text.sv */
// Top level of the fixed-point to decimal text converter.
//
// The input channel (in_valid_i, in_ready_o) takes one signed fixed-point
// value with INT_BITS integer bits and FRAC_BITS fraction bits per request.
// The output channel (out_valid_o, out_ready_i) returns that value's decimal
// text, one ASCII character per request, with last_o high on the final one.
// The integer magnitude runs through a chain of BCD digit cells, one bit per
// cycle. Leading zero digits are then dropped at one cell shift per cycle,
// up to INT_DIGITS - 1 of them. After that, while the receiver keeps up, one
// character leaves per cycle: sign, integer digits, point and the fraction
// digits, each fraction digit made by one multiply by ten. A new request is
// taken once the last character sits in the output register.
// Reset clears the sequencer and the output valid flag; the block then waits
// for a request. When the receiver stalls, the held character stays in the
// output register and the converter waits for it before emitting the next one.
module fixed_to_decimal_text #(
  parameter int INT_BITS        = fdt_pkg::FdtIntBits,
  parameter int FRAC_BITS       = fdt_pkg::FdtFracBits,
  parameter int FRACTION_DIGITS = fdt_pkg::FdtFractionDigits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          char_code_o,
  output logic                                last_o
);
  import fdt_pkg::*;

  localparam int ValueBits  = INT_BITS + FRAC_BITS;
  localparam int INT_DIGITS = (INT_BITS * 3) / 10 + 1;
  localparam int CntW       = $clog2(INT_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_INT   = 3'd4;
  localparam logic [2:0] S_POINT = 3'd5;
  localparam logic [2:0] S_FRAC  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic [INT_BITS-1:0]    whole_q, whole_d;
  logic [FRAC_BITS-1:0]   frac_q, frac_d;
  logic                   out_valid_q;
  logic [7:0]             out_char_q;
  logic                   out_last_q;

  logic [ValueBits-1:0]   mag;
  logic [FRAC_BITS+3:0]   prod;
  logic                   emit_go;
  logic                   emit;
  logic [7:0]             char_d;
  logic                   last_d;
  fdt_cell_ctrl_t         cell_ctrl;

  logic [INT_DIGITS:0]    carry;
  logic [3:0]             digits [INT_DIGITS];
  logic [3:0]             top_digit;

  assign carry[0]  = whole_q[INT_BITS-1];
  assign top_digit = digits[INT_DIGITS-1];

  for (genvar g = 0; g < INT_DIGITS; g++) begin : g_cell
    logic [3:0] lower_digit;
    if (g == 0) begin : g_bottom
      assign lower_digit = 4'd0;
    end else begin : g_upper
      assign lower_digit = digits[g-1];
    end
    fdt_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (carry[g]),
      .digit_i (lower_digit),
      .bit_o   (carry[g+1]),
      .digit_o (digits[g])
    );
  end

  assign mag     = value_i[ValueBits-1] ? $unsigned(-value_i) : $unsigned(value_i);
  assign prod    = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
  assign emit_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    whole_d   = whole_q;
    frac_d    = frac_q;
    cell_ctrl = '0;
    emit      = 1'b0;
    char_d    = AsciiZero;
    last_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cell_ctrl.clear = 1'b1;
          neg_d   = value_i[ValueBits-1];
          whole_d = mag[ValueBits-1:FRAC_BITS];
          frac_d  = mag[FRAC_BITS-1:0];
          cnt_d   = CntW'(INT_BITS - 1);
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        cell_ctrl.dabble = 1'b1;
        whole_d = {whole_q[INT_BITS-2:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = CntW'(INT_DIGITS - 1);
          state_d = S_SKIP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SKIP: begin
        if ((top_digit == 4'd0) && (cnt_q != '0)) begin
          cell_ctrl.move = 1'b1;
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = neg_q ? S_SIGN : S_INT;
        end
      end
      S_SIGN: begin
        if (emit_go) begin
          emit    = 1'b1;
          char_d  = AsciiMinus;
          state_d = S_INT;
        end
      end
      S_INT: begin
        if (emit_go) begin
          emit   = 1'b1;
          char_d = AsciiZero | {4'd0, top_digit};
          cell_ctrl.move = 1'b1;
          if (cnt_q == '0) begin
            state_d = S_POINT;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      S_POINT: begin
        if (emit_go) begin
          emit    = 1'b1;
          char_d  = AsciiPoint;
          cnt_d   = CntW'(FRACTION_DIGITS - 1);
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        if (emit_go) begin
          emit   = 1'b1;
          char_d = AsciiZero | {4'd0, prod[FRAC_BITS+3:FRAC_BITS]};
          frac_d = prod[FRAC_BITS-1:0];
          if (cnt_q == '0) begin
            last_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    whole_q <= whole_d;
    frac_q  <= frac_d;
    if (emit) begin
      out_char_q <= char_d;
      out_last_q <= last_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;
  assign last_o      = out_last_q;

  a_no_digit_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.dabble |-> !carry[INT_DIGITS])
    else $error("BCD chain overflowed its top cell.");

  a_top_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT) |-> (top_digit <= 4'd9))
    else $error("Emitted integer digit is not decimal.");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CONV))
    else $error("Accepted request did not start conversion.");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRAC && emit_go && cnt_q == '0) |=>
      (state_q == S_IDLE && out_valid_q && out_last_q))
    else $error("Final fraction digit did not end the text.");

endmodule

/* bench/fixed_to_decimal_text_test.sv */
// Testbench for the fixed-point to decimal text converter, checked against its own text predictor.
module fixed_to_decimal_text_test;
  import fdt_pkg::*;

  localparam int ValueBits     = FdtIntBits + FdtFracBits;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 64;
  localparam int MaxPrinted    = 40;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [ValueBits-1:0] value_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [7:0]                  char_code_o;
  logic                        last_o;

  text_char_t  expected_chars[$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned send_gap_max = 8;
  int unsigned recv_stall_max = 8;

  fixed_to_decimal_text u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MaxPrinted) $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  // Builds the expected characters of one value: sign, integer digits, point, fraction digits.
  function automatic void predict_text(input logic [ValueBits-1:0] v);
    logic [ValueBits-1:0]    mag;
    logic [FdtIntBits-1:0]   whole;
    logic [FdtFracBits+3:0]  frac;
    logic [7:0]              text[$];
    logic [7:0]              digits[$];
    int                      n;
    mag   = v[ValueBits-1] ? (~v + 1'b1) : v;
    whole = mag[ValueBits-1:FdtFracBits];
    frac  = {4'b0, mag[FdtFracBits-1:0]};
    if (v[ValueBits-1]) text.push_back(AsciiMinus);
    if (whole == 0) begin
      digits.push_back(AsciiZero);
    end else begin
      while (whole != 0) begin
        digits.push_front(AsciiZero + 8'(whole % 10));
        whole = whole / 10;
      end
    end
    foreach (digits[i]) text.push_back(digits[i]);
    text.push_back(AsciiPoint);
    for (int i = 0; i < FdtFractionDigits; i++) begin
      frac = frac * (FdtFracBits + 4)'(10);
      text.push_back(AsciiZero + 8'(frac >> FdtFracBits));
      frac = frac & {{4{1'b0}}, {FdtFracBits{1'b1}}};
    end
    n = text.size();
    for (int i = 0; i < n; i++) expected_chars.push_back('{text[i], (i == n - 1)});
  endfunction

  function automatic logic [ValueBits-1:0] make_value(input longint unsigned whole,
                                                      input logic [FdtFracBits-1:0] frac,
                                                      input bit neg);
    logic [ValueBits-1:0] mag;
    mag = {whole[FdtIntBits-1:0], frac};
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  function automatic logic [ValueBits-1:0] random_value();
    int unsigned     n;
    longint unsigned lo;
    longint unsigned hi;
    case ($urandom_range(0, 3))
      0: return ValueBits'({$urandom, $urandom});
      1: begin
        n  = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        return make_value(64'($urandom_range(32'(hi), 32'(lo))), 16'($urandom),
                          1'($urandom_range(0, 1)));
      end
      2: return make_value(64'($urandom_range(0, 3)), 16'($urandom),
                           1'($urandom_range(0, 1)));
      default: return make_value(64'($urandom_range(0, 9)), 16'($urandom_range(0, 200)),
                                 1'($urandom_range(0, 1)));
    endcase
  endfunction

  // Leaves the task at the edge where the request was taken.
  task automatic send_value(input logic [ValueBits-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predict_text(v);
  endtask

  task automatic test_directed_cases();
    send_value(make_value(0, 16'h0000, 0));
    send_value(make_value(0, 16'h0001, 0));
    send_value(make_value(0, 16'h0001, 1));
    send_value(make_value(0, 16'h8000, 0));
    send_value(make_value(0, 16'h8000, 1));
    send_value(make_value(1, 16'h0000, 0));
    send_value(make_value(1, 16'h0000, 1));
    send_value(make_value(64'd2147483647, 16'hffff, 0));
    send_value(make_value(64'd2147483648, 16'h0000, 1));
    send_value(make_value(64'd2147483647, 16'hffff, 1));
    send_value(make_value(0, 16'hffff, 0));
    send_value(make_value(0, 16'hffff, 1));
    send_value(make_value(10, 16'h0000, 0));
    send_value(make_value(64'd1000000000, 16'h0042, 0));
    send_value(make_value(64'd999999999, 16'h0041, 1));
    send_value(make_value(123, 16'h74bc, 0));
    send_value(make_value(100, 16'h1999, 1));
    send_value({ValueBits{1'b1}});
    send_value({1'b0, {(ValueBits - 1){1'b1}}});
  endtask

  task automatic test_digit_counts();
    longint unsigned p;
    p = 1;
    for (int n = 1; n <= 10; n++) begin
      for (int s = 0; s < 2; s++) begin
        send_value(make_value(p, 16'($urandom), s[0]));
        send_value(make_value((p * 10 - 1 > 64'd2147483647) ? 64'd2147483647 : p * 10 - 1,
                              16'($urandom), s[0]));
      end
      p = p * 10;
    end
  endtask

  task automatic test_random_values();
    for (int i = 0; i < 180; i++) begin
      if (i % 30 == 0) begin
        send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      send_value(random_value());
    end
  endtask

  task automatic test_back_to_back();
    send_gap_max   = 0;
    recv_stall_max = 0;
    repeat (100) send_value(random_value());
  endtask

  task automatic test_long_stalls();
    send_gap_max   = 8;
    recv_stall_max = 8;
    repeat (90) send_value(random_value());
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) stall_left = $urandom_range(0, recv_stall_max);
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", char_code_o, last_o));
      end else begin
        want = expected_chars.pop_front();
        if (char_code_o !== want.code)
          report_mismatch($sformatf("char_code %h, wanted %h", char_code_o, want.code));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", last_o, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_ready_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_digit_counts();
    test_random_values();
    test_back_to_back();
    test_long_stalls();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
design/fdt_pkg.sv
design/fdt_bcd_cell.sv
design/fixed_to_decimal_text.sv
bench/fixed_to_decimal_text_test.sv
